@@ hdl/spt_pkg.sv @@
`default_nettype none

package spt_pkg;

    // default sizes of the table
    localparam int CAPACITY_DEF = 64;
    localparam int COORD_W_DEF  = 16;

    // fixed field widths on the streams
    localparam int ACT_W   = 3;
    localparam int FIELD_W = 16;
    localparam int POS_W   = 6;
    localparam int RC_W    = 7;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    // action codes carried in the slave-side tuser
    typedef enum logic [ACT_W-1:0] {
        ACT_ADD       = 3'd0,
        ACT_REM_FIRST = 3'd1,
        ACT_REM_LAST  = 3'd2,
        ACT_REM_IDX   = 3'd3,
        ACT_DEDUP     = 3'd4
    } t_action;

    // verdict of the shared compare unit
    typedef struct packed {
        logic lt;   // a sorts strictly before b
        logic eq;   // a and b are the same point
    } t_cmp_res;

endpackage

`default_nettype wire

@@ hdl/spt_ram.sv @@
`default_nettype none

module spt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/spt_cmp.sv @@
`default_nettype none

module spt_cmp #(
    parameter int COORD_W = spt_pkg::COORD_W_DEF
) (
    input  wire logic [4*COORD_W-1:0] i_a,
    input  wire logic [4*COORD_W-1:0] i_b,
    output spt_pkg::t_cmp_res         o_res
);
    import spt_pkg::*;

    localparam int DW = 2 * COORD_W;

    // record layout: squared distance, x, y from the top down
    logic        [DW-1:0]      a_d, b_d;
    logic signed [COORD_W-1:0] a_x, b_x, a_y, b_y;

    assign a_d = i_a[4*COORD_W-1:DW];
    assign b_d = i_b[4*COORD_W-1:DW];
    assign a_x = i_a[DW-1:COORD_W];
    assign b_x = i_b[DW-1:COORD_W];
    assign a_y = i_a[COORD_W-1:0];
    assign b_y = i_b[COORD_W-1:0];

    // lexicographic order: distance, then signed x, then signed y
    always_comb begin
        priority if (a_d != b_d) begin
            o_res.lt = (a_d < b_d);
        end else if (a_x != b_x) begin
            o_res.lt = (a_x < b_x);
        end else begin
            o_res.lt = (a_y < b_y);
        end
        o_res.eq = (a_d == b_d) && (a_x == b_x) && (a_y == b_y);
    end

endmodule

`default_nettype wire

@@ hdl/sorted_point_table.sv @@
`default_nettype none
// channel   direction  tdata (low bit up)                     tuser
// s_axis    in         in_x[15:0] in_y[31:16] position[37:32] action[2:0]
// m_axis    out        out_x[15:0] out_y[31:16] removed[38:32] ok[0]
//
// one beat at a time; s_axis tready is high only while the sequencer is idle
// add: square x, square y, read and compare each stored entry, write the new last entry
// removes and delete duplicates: read, then keep or drop, each entry from the start index
// failed actions and spare codes skip to the result; one memory read port sets the steps
// a result may wait in the output register while the next beat is taken
// reset (synchronous, active low) empties the table; no memory clearing pass

module sorted_point_table #(
    parameter int CAPACITY    = spt_pkg::CAPACITY_DEF,
    parameter int COORD_WIDTH = spt_pkg::COORD_W_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // in_x, in_y, position, zero pad
    input  wire logic [spt_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // action
    input  wire logic [spt_pkg::ACT_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    // out_x, out_y, removed_count, zero pad
    output logic      [spt_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // ok
    output logic      [0:0]                   o_m_axis_tuser
);
    import spt_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = 2 * CW;
    localparam int EW    = 2 * DW;
    localparam int AW    = $clog2(CAPACITY);
    localparam int FW    = $clog2(CAPACITY + 1);
    localparam int EXT_W = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int CMP_W = (FW > POS_W) ? FW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQY, S_ARD, S_APR, S_AEND, S_CRD, S_CPR, S_FIN
    } t_state;

    t_state               r_state, n_state;
    logic [FW-1:0]        r_fill, n_fill;
    logic [FW-1:0]        r_k, n_k;
    logic [FW-1:0]        r_keep, n_keep;
    logic [FW-1:0]        r_start, n_start;
    logic [ACT_W-1:0]     r_act, n_act;
    logic [CW-1:0]        r_nx, n_nx;
    logic [CW-1:0]        r_ny, n_ny;
    logic [DW-1:0]        r_dist, n_dist;
    logic [EW-1:0]        r_carry, n_carry;
    logic [EW-1:0]        r_last, n_last;
    logic                 r_ins, n_ins;
    logic                 r_have, n_have;
    logic                 r_ok, n_ok;
    logic [FIELD_W-1:0]   r_ox, n_ox;
    logic [FIELD_W-1:0]   r_oy, n_oy;
    logic [RC_W-1:0]      r_rc, n_rc;
    logic                 r_m_valid, n_m_valid;
    logic                 r_m_ok, n_m_ok;
    logic [FIELD_W-1:0]   r_m_x, n_m_x;
    logic [FIELD_W-1:0]   r_m_y, n_m_y;
    logic [RC_W-1:0]      r_m_rc, n_m_rc;

    logic                 s_acc;
    logic                 drop;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [EW-1:0]        mem_wdata;
    logic [EW-1:0]        mem_rdata;
    logic [EW-1:0]        cmp_a, cmp_b;
    t_cmp_res             cmp_res;
    logic signed [CW-1:0] mul_op;
    logic signed [DW-1:0] w_sq;
    logic [DW-1:0]        w_dsum;
    logic [EXT_W-1:0]     w_inx_ext, w_iny_ext;
    logic signed [CW-1:0] w_rx, w_ry;
    logic signed [EXT_W-1:0] w_rx_ext, w_ry_ext;

    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;

    // incoming coordinates reduced to the table's coordinate width
    assign w_inx_ext = EXT_W'(i_s_axis_tdata[FIELD_W-1:0]);
    assign w_iny_ext = EXT_W'(i_s_axis_tdata[2*FIELD_W-1:FIELD_W]);

    // shared squaring multiplier, x first then y
    assign mul_op = (r_state == S_SQY) ? r_ny : r_nx;
    assign w_sq   = mul_op * mul_op;
    assign w_dsum = r_dist + $unsigned(w_sq);

    // entry read back, widened to the output field
    assign w_rx     = mem_rdata[DW-1:CW];
    assign w_ry     = mem_rdata[CW-1:0];
    assign w_rx_ext = EXT_W'(w_rx);
    assign w_ry_ext = EXT_W'(w_ry);

    // compare unit: new point against entry, or entry against last kept
    assign cmp_a = (r_state == S_APR) ? r_carry : mem_rdata;
    assign cmp_b = (r_state == S_APR) ? mem_rdata : r_last;

    spt_cmp #(
        .COORD_W (CW)
    ) u_cmp (
        .i_a   (cmp_a),
        .i_b   (cmp_b),
        .o_res (cmp_res)
    );

    spt_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // entry drop decision while compacting
    always_comb begin
        if (r_act == ACT_DEDUP) begin
            drop = r_have && cmp_res.eq;
        end else begin
            drop = (r_k == r_start);
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_k       = r_k;
        n_keep    = r_keep;
        n_start   = r_start;
        n_act     = r_act;
        n_nx      = r_nx;
        n_ny      = r_ny;
        n_dist    = r_dist;
        n_carry   = r_carry;
        n_last    = r_last;
        n_ins     = r_ins;
        n_have    = r_have;
        n_ok      = r_ok;
        n_ox      = r_ox;
        n_oy      = r_oy;
        n_rc      = r_rc;
        n_m_valid = r_m_valid;
        n_m_ok    = r_m_ok;
        n_m_x     = r_m_x;
        n_m_y     = r_m_y;
        n_m_rc    = r_m_rc;
        mem_we    = 1'b0;
        mem_waddr = r_k[AW-1:0];
        mem_wdata = r_carry;

        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_act  = i_s_axis_tuser;
                    n_nx   = w_inx_ext[CW-1:0];
                    n_ny   = w_iny_ext[CW-1:0];
                    n_ok   = 1'b0;
                    n_ox   = '0;
                    n_oy   = '0;
                    n_rc   = '0;
                    n_k    = '0;
                    n_keep = '0;
                    n_ins  = 1'b0;
                    n_have = 1'b0;
                    n_start = '0;
                    n_state = S_FIN;
                    unique case (i_s_axis_tuser)
                        ACT_ADD: begin
                            if (r_fill != FW'(CAPACITY)) begin
                                n_state = S_SQX;
                            end
                        end
                        ACT_REM_FIRST: begin
                            if (r_fill != '0) begin
                                n_state = S_CRD;
                            end
                        end
                        ACT_REM_LAST: begin
                            if (r_fill != '0) begin
                                n_start = r_fill - 1'b1;
                                n_k     = r_fill - 1'b1;
                                n_keep  = r_fill - 1'b1;
                                n_state = S_CRD;
                            end
                        end
                        ACT_REM_IDX: begin
                            if (CMP_W'(i_s_axis_tdata[2*FIELD_W+POS_W-1:2*FIELD_W])
                                    < CMP_W'(r_fill)) begin
                                n_start = FW'(i_s_axis_tdata[2*FIELD_W+POS_W-1:2*FIELD_W]);
                                n_k     = FW'(i_s_axis_tdata[2*FIELD_W+POS_W-1:2*FIELD_W]);
                                n_keep  = FW'(i_s_axis_tdata[2*FIELD_W+POS_W-1:2*FIELD_W]);
                                n_state = S_CRD;
                            end
                        end
                        ACT_DEDUP: begin
                            n_state = S_CRD;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_SQX: begin
                n_dist  = $unsigned(w_sq);
                n_state = S_SQY;
            end
            S_SQY: begin
                n_carry = {w_dsum, r_nx, r_ny};
                n_state = S_ARD;
            end
            // insertion pass: once placed, every later entry moves up one slot
            S_ARD: begin
                if (r_k == r_fill) begin
                    n_state = S_AEND;
                end else begin
                    n_state = S_APR;
                end
            end
            S_APR: begin
                if (r_ins || cmp_res.lt) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_k[AW-1:0];
                    mem_wdata = r_carry;
                    n_carry   = mem_rdata;
                    n_ins     = 1'b1;
                end
                n_k     = r_k + 1'b1;
                n_state = S_ARD;
            end
            S_AEND: begin
                mem_we    = 1'b1;
                mem_waddr = r_fill[AW-1:0];
                mem_wdata = r_carry;
                n_fill    = r_fill + 1'b1;
                n_ok      = 1'b1;
                n_state   = S_FIN;
            end
            // compaction pass for removes and duplicate deletion
            S_CRD: begin
                if (r_k == r_fill) begin
                    n_fill = r_keep;
                    n_ok   = 1'b1;
                    if (r_act == ACT_DEDUP) begin
                        n_rc = RC_W'(r_k - r_keep);
                    end
                    n_state = S_FIN;
                end else begin
                    n_state = S_CPR;
                end
            end
            S_CPR: begin
                if (drop) begin
                    if (r_act != ACT_DEDUP) begin
                        n_ox = w_rx_ext[FIELD_W-1:0];
                        n_oy = w_ry_ext[FIELD_W-1:0];
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_keep[AW-1:0];
                    mem_wdata = mem_rdata;
                    n_keep    = r_keep + 1'b1;
                    n_last    = mem_rdata;
                    n_have    = 1'b1;
                end
                n_k     = r_k + 1'b1;
                n_state = S_CRD;
            end
            S_FIN: begin
                if (!r_m_valid || i_m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_ok    = r_ok;
                    n_m_x     = r_ox;
                    n_m_y     = r_oy;
                    n_m_rc    = r_rc;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_m_valid <= n_m_valid;
        end
        r_k     <= n_k;
        r_keep  <= n_keep;
        r_start <= n_start;
        r_act   <= n_act;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_dist  <= n_dist;
        r_carry <= n_carry;
        r_last  <= n_last;
        r_ins   <= n_ins;
        r_have  <= n_have;
        r_ok    <= n_ok;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_rc    <= n_rc;
        r_m_ok  <= n_m_ok;
        r_m_x   <= n_m_x;
        r_m_y   <= n_m_y;
        r_m_rc  <= n_m_rc;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_m_rc, r_m_y, r_m_x};
    assign o_m_axis_tuser  = r_m_ok;

endmodule

`default_nettype wire

@@ hdl/spt_chk.sv @@
`default_nettype none

module spt_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_s_axis_tvalid,
    input wire logic                         o_s_axis_tready,
    input wire logic                         o_m_axis_tvalid,
    input wire logic                         i_m_axis_tready,
    input wire logic [spt_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    input wire logic [0:0]                   o_m_axis_tuser
);
    import spt_pkg::*;

    // a waiting result beat holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // one beat in flight: the sequencer leaves idle after every accepted beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again before the previous action finished");

    // a failed action reports no point and no count
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |->
            o_m_axis_tdata[2*FIELD_W+RC_W-1:0] == '0)
        else $error("failed action carries nonzero payload");

    // a duplicate count only comes with success and no removed point
    a_count_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[2*FIELD_W+RC_W-1:2*FIELD_W] != '0) |->
            o_m_axis_tuser[0] && (o_m_axis_tdata[2*FIELD_W-1:0] == '0))
        else $error("duplicate count mixed with a removed point");

endmodule

bind sorted_point_table spt_chk u_spt_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

@@ test/point_table_checker.sv @@
`timescale 1ns / 1ps

module point_table_checker
    import spt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    input  wire logic                i_s_tready,
    // in_x, in_y, position, zero pad
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    // action
    input  wire logic [ACT_W-1:0]    i_s_tuser,
    input  wire logic                i_m_tvalid,
    input  wire logic                i_m_tready,
    // out_x, out_y, removed_count, zero pad
    input  wire logic [M_DATA_W-1:0] i_m_tdata,
    // ok
    input  wire logic [0:0]          i_m_tuser,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked,
    output int                       o_full_refusals,
    output int                       o_dups_removed
);

    // one result beat, as the output channel carries it
    typedef struct packed {
        logic              ok;
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic [RC_W-1:0]    removed;
    } t_table_result;

    // shadow copy of the sorted table
    logic signed [FIELD_W-1:0] tbl_x    [CAPACITY];
    logic signed [FIELD_W-1:0] tbl_y    [CAPACITY];
    longint                    tbl_dist [CAPACITY];
    int                        tbl_fill;

    t_table_result awaited_results [$];
    t_table_result want;
    t_table_result got;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_checked       = 0;
        o_full_refusals = 0;
        o_dups_removed  = 0;
        tbl_fill        = 0;
    end

    // new point sorts strictly ahead of stored entry idx
    function automatic bit point_precedes(input longint d, input logic signed [FIELD_W-1:0] px,
                                          input logic signed [FIELD_W-1:0] py, input int idx);
        if (d != tbl_dist[idx])
            return d < tbl_dist[idx];
        if (px != tbl_x[idx])
            return px < tbl_x[idx];
        return py < tbl_y[idx];
    endfunction

    // pull entry idx out and close the gap behind it
    function automatic t_table_result take_at(input int idx);
        t_table_result res;
        res         = '0;
        res.ok      = 1'b1;
        res.x       = tbl_x[idx];
        res.y       = tbl_y[idx];
        for (int k = idx; k + 1 < tbl_fill; k++) begin
            tbl_x[k]    = tbl_x[k + 1];
            tbl_y[k]    = tbl_y[k + 1];
            tbl_dist[k] = tbl_dist[k + 1];
        end
        tbl_fill--;
        return res;
    endfunction

    // apply one action to the shadow table and give the result it yields
    function automatic t_table_result apply_to_table(input logic [ACT_W-1:0] act,
                                                     input logic signed [FIELD_W-1:0] px,
                                                     input logic signed [FIELD_W-1:0] py,
                                                     input logic [POS_W-1:0] pos);
        t_table_result res;
        longint        d;
        int            slot;
        int            keep;
        int            gone;
        res = '0;
        d   = longint'(px) * longint'(px) + longint'(py) * longint'(py);
        case (act)
            ACT_ADD: begin
                if (tbl_fill >= CAPACITY) begin
                    o_full_refusals++;
                end else begin
                    slot = 0;
                    while (slot < tbl_fill && !point_precedes(d, px, py, slot))
                        slot++;
                    for (int k = tbl_fill; k > slot; k--) begin
                        tbl_x[k]    = tbl_x[k - 1];
                        tbl_y[k]    = tbl_y[k - 1];
                        tbl_dist[k] = tbl_dist[k - 1];
                    end
                    tbl_x[slot]    = px;
                    tbl_y[slot]    = py;
                    tbl_dist[slot] = d;
                    tbl_fill++;
                    res.ok = 1'b1;
                end
            end
            ACT_REM_FIRST: begin
                if (tbl_fill > 0)
                    res = take_at(0);
            end
            ACT_REM_LAST: begin
                if (tbl_fill > 0)
                    res = take_at(tbl_fill - 1);
            end
            ACT_REM_IDX: begin
                if (int'(pos) < tbl_fill)
                    res = take_at(int'(pos));
            end
            ACT_DEDUP: begin
                keep = 0;
                gone = 0;
                for (int k = 0; k < tbl_fill; k++) begin
                    if (keep > 0 && tbl_dist[k] == tbl_dist[keep - 1] &&
                        tbl_x[k] == tbl_x[keep - 1] && tbl_y[k] == tbl_y[keep - 1]) begin
                        gone++;
                    end else begin
                        tbl_x[keep]    = tbl_x[k];
                        tbl_y[keep]    = tbl_y[k];
                        tbl_dist[keep] = tbl_dist[k];
                        keep++;
                    end
                end
                tbl_fill        = keep;
                o_dups_removed += gone;
                res.ok          = 1'b1;
                res.removed     = gone[RC_W-1:0];
            end
            default: begin
                // spare codes leave the table alone and answer all zero
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input longint exp_val, input longint act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    // watch both channels; results are checked before the new beat is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_fill = 0;
            awaited_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.ok      = i_m_tuser[0];
                got.x       = i_m_tdata[15:0];
                got.y       = i_m_tdata[31:16];
                got.removed = i_m_tdata[38:32];
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing awaited: ok %0d x %0d y %0d removed %0d",
                           got.ok, $signed(got.x), $signed(got.y), got.removed);
                    o_fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("ok", want.ok, got.ok);
                    check_field("out_x", $signed(want.x), $signed(got.x));
                    check_field("out_y", $signed(want.y), $signed(got.y));
                    check_field("removed_count", want.removed, got.removed);
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready)
                awaited_results.push_back(apply_to_table(i_s_tuser, i_s_tdata[15:0],
                                                         i_s_tdata[31:16], i_s_tdata[37:32]));
        end
        o_pending = awaited_results.size();
    end

endmodule

@@ test/sorted_point_table_test.sv @@
`timescale 1ns / 1ps

module sorted_point_table_test;

    import spt_pkg::*;

    localparam int  HALF_PERIOD  = 6;
    localparam int  RANDOM_BEATS = 1850;
    localparam int  HOLD_AT      = 600;
    localparam int  HOLD_CYCLES  = 500;
    localparam int  TAIL_CYCLES  = 300;
    localparam longint LIMIT_NS  = 64'd20_000_000;

    // action codes the block does not define
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_MID   = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

    localparam logic [FIELD_W-1:0] COORD_MIN = 16'h8000;
    localparam logic [FIELD_W-1:0] COORD_MAX = 16'h7fff;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [ACT_W-1:0]    s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [0:0]          m_tuser;

    int fail_count;
    int pending;
    int checked;
    int full_refusals;
    int dups_removed;
    int beats_sent;
    bit hold_done;

    sorted_point_table dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    point_table_checker chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_full_refusals (full_refusals),
        .o_dups_removed  (dups_removed)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // offer one beat from the falling edge and hold it until taken
    task automatic send_beat(input logic [ACT_W-1:0] act, input logic [FIELD_W-1:0] x,
                             input logic [FIELD_W-1:0] y, input logic [POS_W-1:0] pos);
        @(negedge clk);
        s_tdata  = {2'b00, pos, y, x};
        s_tuser  = act;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
    endtask

    // often a small grid for ties and duplicates, some extremes, some anything
    function automatic logic [FIELD_W-1:0] pick_coord();
        int roll;
        int v;
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            v = int'($urandom_range(0, 10)) - 5;
            return v[FIELD_W-1:0];
        end
        if (roll < 6) begin
            case ($urandom_range(0, 4))
                0: return COORD_MIN;
                1: return COORD_MAX;
                2: return '0;
                3: return '1;
                default: return COORD_MIN + 1'b1;
            endcase
        end
        return FIELD_W'($urandom);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if ($urandom_range(0, 1) == 0)
            return POS_W'($urandom_range(0, 63));
        return POS_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input int add_pct);
        int roll;
        if ($urandom_range(0, 99) < add_pct)
            return ACT_ADD;
        roll = $urandom_range(0, 19);
        if (roll < 5)
            return ACT_REM_FIRST;
        if (roll < 10)
            return ACT_REM_LAST;
        if (roll < 15)
            return ACT_REM_IDX;
        if (roll < 19)
            return ACT_DEDUP;
        return ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    endfunction

    // receiver: stall segments of varying density, plus one long hold-off
    initial begin
        int seg_len;
        int stall_pct;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            seg_len = $urandom_range(16, 160);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (seg_len) begin
                @(negedge clk);
                if (!hold_done && beats_sent >= HOLD_AT) begin
                    m_tready = 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // stimulus and verdict
    initial begin
        int done;
        int chunk;
        int add_pct;
        int mode;
        int gap;
        int burst_left;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ACT_ADD;
        beats_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table: every remove fails, dedup removes nothing
        send_beat(ACT_REM_FIRST, '0, '0, '0);
        send_beat(ACT_REM_LAST, '0, '0, '0);
        send_beat(ACT_REM_IDX, '0, '0, '0);
        send_beat(ACT_DEDUP, '0, '0, '0);
        // single entry, then extremes and equal-distance ties
        send_beat(ACT_ADD, '0, '0, '0);
        send_beat(ACT_DEDUP, '0, '0, '0);
        send_beat(ACT_ADD, COORD_MIN, COORD_MIN, '1);
        send_beat(ACT_ADD, COORD_MAX, COORD_MAX, '0);
        send_beat(ACT_ADD, COORD_MAX, COORD_MIN, '0);
        send_beat(ACT_ADD, 16'd3, 16'd4, '0);
        send_beat(ACT_ADD, 16'd4, 16'd3, '0);
        send_beat(ACT_ADD, -16'sd3, 16'd4, '0);
        send_beat(ACT_ADD, 16'd3, -16'sd4, '0);
        send_beat(ACT_ADD, 16'd4, 16'd3, '0);
        send_beat(ACT_ADD, '0, '0, '0);
        // index past the fill level, then the spare codes
        send_beat(ACT_REM_IDX, '0, '0, '1);
        send_beat(ACT_SPARE_FIRST, COORD_MAX, COORD_MAX, '1);
        send_beat(ACT_SPARE_MID, COORD_MIN, COORD_MIN, '0);
        send_beat(ACT_SPARE_LAST, '1, '1, '1);
        send_beat(ACT_DEDUP, '0, '0, '0);
        send_beat(ACT_REM_IDX, '0, '0, 6'd2);
        send_beat(ACT_REM_LAST, '0, '0, '0);
        send_beat(ACT_REM_FIRST, '0, '0, '0);
        send_beat(ACT_ADD, '1, '1, '0);

        // let the block drain completely before the random part
        idle_for(1);
        wait (pending == 0);

        // random part: fill, mixed and drain phases in turn
        done       = 0;
        mode       = 0;
        burst_left = $urandom_range(1, 32);
        while (done < RANDOM_BEATS) begin
            chunk   = $urandom_range(100, 220);
            add_pct = (mode == 0) ? 85 : (mode == 1) ? 50 : 12;
            for (int i = 0; i < chunk && done < RANDOM_BEATS; i++) begin
                send_beat(pick_action(add_pct), pick_coord(), pick_coord(), pick_position());
                done++;
                burst_left--;
                if (burst_left <= 0) begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0)
                        idle_for(gap);
                    burst_left = $urandom_range(1, 32);
                end
            end
            mode = (mode + 1) % 3;
            if ($urandom_range(0, 3) == 0) begin
                idle_for(1);
                wait (pending == 0);
            end
        end

        idle_for(1);
        wait (pending == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d beats sent, %0d results checked", beats_sent, checked);
        $display("run: %0d adds refused on a full table, %0d duplicates deleted",
                 full_refusals, dups_removed);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
